// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL of the dose accumulator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define DNA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset
`define DNA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: rtl/dna_pkg.sv
// ----------------------------------------------------------------------------
// dna_pkg
// Widths, dose factor table and shared types of the neutron dose accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package dna_pkg;

  // Field widths
  localparam int unsigned VolW   = 4;
  localparam int unsigned CodeW  = 24;
  localparam int unsigned EW     = 45;   // energy, 2^-36 MeV
  localparam int unsigned PW     = 24;   // path, 2^-8 mm
  localparam int unsigned CW     = 27;   // dose factor, 2^-40
  localparam int unsigned IW     = 48;   // dose increment, 2^-48
  localparam int unsigned SumW   = 64;
  localparam int unsigned CntW   = 32;

  // Interpolation table
  localparam int unsigned NumPoints = 22;
  localparam int unsigned SegW      = $clog2(NumPoints);

  // Datapath width of the serial multiplier / divider (73-bit numerator + 1)
  localparam int unsigned NW   = 74;
  localparam int unsigned ItW  = 6;      // iteration counter, holds up to EW-1

  localparam logic [CodeW-1:0] DefaultParticle = 24'd2112;
  localparam logic [3:0]       PathDivisor     = 4'd10;   // mm to cm

  // Energy break points, 2^-36 MeV
  localparam logic [EW-1:0] E_TAB [NumPoints] = '{
    45'd1718, 45'd6872, 45'd68719, 45'd687195, 45'd6871948,
    45'd68719477, 45'd687194767, 45'd6871947674, 45'd34359738368,
    45'd68719476736, 45'd171798691840, 45'd343597383680, 45'd481036337152,
    45'd687194767360, 45'd962072674304, 45'd1374389534720,
    45'd2748779069440, 45'd4123168604160, 45'd6871947673600,
    45'd13743895347200, 45'd20615843020800, 45'd27487790694400
  };

  // Dose factors at the break points, 2^-40
  localparam logic [CW-1:0] C_TAB [NumPoints] = '{
    27'd1122601, 27'd1122601, 27'd1363394, 27'd1363394, 27'd1316115,
    27'd1122601, 27'd1090825, 27'd6639951, 27'd28279439, 27'd40187150,
    27'd38175044, 27'd47718805, 27'd44915050, 27'd44915050, 27'd63628738,
    27'd69412169, 27'd76350087, 27'd69412169, 27'd54535777, 27'd58735911,
    27'd69412169, 27'd76350087
  };

  // Per-volume sums as stored in one memory word
  typedef struct packed {
    logic [SumW-1:0] dose;
    logic [CntW-1:0] hits;
    logic [SumW-1:0] energy;
    logic [SumW-1:0] path;
  } sums_t;

  // Dose factor unit request and response
  typedef struct packed {
    logic          start;
    logic [EW-1:0] energy;
    logic [PW-1:0] path;
  } fac_req_t;

  typedef struct packed {
    logic          done;
    logic [IW-1:0] inc;
  } fac_rsp_t;

endpackage

`default_nettype wire

// File: rtl/neutron_dose_accumulator_unit.sv
// ----------------------------------------------------------------------------
// neutron_dose_accumulator_unit
// Accumulates dose, hit count, energy and path per detector volume for hits
// of one configured particle; dose factor from a piecewise linear table.
// ----------------------------------------------------------------------------
//  channel   dir  bits  contents
//  s_axis    in   104   volume, particle_code, energy, path_length
//  m_axis    out  272   dose_increment, volume sums; tuser = accepted
//  cfg       in   24    accepted_particle
//
//  An accepted hit inside the table range has its result formed by the
//  45-step serial multiply, the 27-step restoring division and the
//  scaling and divide-by-ten states in dna_factor. A clamped hit skips
//  the multiply and division and goes straight to scaling; a rejected
//  hit bypasses dna_factor. One hit is in work at a time; the next is
//  taken as soon as the result sits in the output register. Reset clears
//  the per-volume valid bits at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module neutron_dose_accumulator_unit #(
  parameter int unsigned NUM_VOLUMES = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // volume[3:0], particle_code[27:4], energy[72:28], path_length[96:73]
  input  wire logic [103:0] s_axis_tdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // dose_increment[47:0], volume_dose_sum[111:48], volume_hit_count[143:112],
  // volume_energy_sum[207:144], volume_path_sum[271:208]
  output logic [271:0]      m_axis_tdata,
  // accepted[0]
  output logic [0:0]        m_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic         cfg_we_i,
  input  wire logic [23:0]  cfg_wdata_i
);

  localparam int unsigned AW = (NUM_VOLUMES > 1) ? $clog2(NUM_VOLUMES) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_q, state_d;

  // Input field split
  logic [dna_pkg::VolW-1:0]  in_vol;
  logic [dna_pkg::CodeW-1:0] in_code;
  logic [dna_pkg::EW-1:0]    in_energy;
  logic [dna_pkg::PW-1:0]    in_path;
  logic                      in_acc, vol_ok, hit;

  assign in_vol    = s_axis_tdata[3:0];
  assign in_code   = s_axis_tdata[27:4];
  assign in_energy = s_axis_tdata[72:28];
  assign in_path   = s_axis_tdata[96:73];

  logic [dna_pkg::CodeW-1:0] part_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign vol_ok        = (in_vol != '0) && ({1'b0, in_vol} <= 5'(NUM_VOLUMES));
  assign hit           = vol_ok && (in_code == part_q);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= dna_pkg::DefaultParticle;
    end else if (cfg_we_i) begin
      part_q <= cfg_wdata_i;
    end
  end

  // Hit context held while the increment is computed
  logic                   vol_ok_q, hit_q;
  logic [AW-1:0]          idx_q;
  logic [dna_pkg::EW-1:0] e_q;
  logic [dna_pkg::PW-1:0] p_q;
  logic [dna_pkg::IW-1:0] inc_q;

  dna_pkg::fac_req_t fac_req;
  dna_pkg::fac_rsp_t fac_rsp;

  assign fac_req.start  = in_acc && hit;
  assign fac_req.energy = in_energy;
  assign fac_req.path   = in_path;

  dna_factor u_factor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fac_req),
    .rsp_o  (fac_rsp)
  );

  // Sum memory, read at accept, written back on result hand-off
  dna_pkg::sums_t rd_sums, new_sums, res_sums;
  logic           out_free, out_load, mem_wr;

  dna_sum_mem #(
    .Depth (NUM_VOLUMES),
    .AW    (AW)
  ) u_sum_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc && vol_ok),
    .rd_addr_i (AW'(in_vol - 1'b1)),
    .rd_data_o (rd_sums),
    .wr_en_i   (mem_wr),
    .wr_addr_i (idx_q),
    .wr_data_i (new_sums)
  );

  // Saturating updates
  logic [dna_pkg::SumW:0] dose_x, energy_x, path_x;

  always_comb begin
    dose_x   = {1'b0, rd_sums.dose}   + (dna_pkg::SumW+1)'(inc_q);
    energy_x = {1'b0, rd_sums.energy} + (dna_pkg::SumW+1)'(e_q);
    path_x   = {1'b0, rd_sums.path}   + (dna_pkg::SumW+1)'(p_q);
    new_sums.dose   = dose_x[dna_pkg::SumW]   ? '1 : dose_x[dna_pkg::SumW-1:0];
    new_sums.energy = energy_x[dna_pkg::SumW] ? '1 : energy_x[dna_pkg::SumW-1:0];
    new_sums.path   = path_x[dna_pkg::SumW]   ? '1 : path_x[dna_pkg::SumW-1:0];
    new_sums.hits   = (rd_sums.hits == '1) ? rd_sums.hits : rd_sums.hits + 1'b1;
    if (hit_q) begin
      res_sums = new_sums;
    end else if (vol_ok_q) begin
      res_sums = rd_sums;
    end else begin
      res_sums = '0;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state_q == S_UPD) && out_free;
  assign mem_wr   = out_load && hit_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = hit ? S_CALC : S_UPD;
        end
      end
      S_CALC: begin
        if (fac_rsp.done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Hit context and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vol_ok_q <= vol_ok;
      hit_q    <= hit;
      idx_q    <= AW'(in_vol - 1'b1);
      e_q      <= in_energy;
      p_q      <= in_path;
      inc_q    <= '0;
    end else if ((state_q == S_CALC) && fac_rsp.done) begin
      inc_q <= fac_rsp.inc;
    end
    if (out_load) begin
      m_axis_tuser <= hit_q;
      m_axis_tdata <= {res_sums.path, res_sums.energy, res_sums.hits,
                       res_sums.dose, inc_q};
    end
  end

  // Assertions
  `DNA_ASSERT(a_done_in_calc, clk_i, rst_ni, fac_rsp.done |-> state_q == S_CALC,
    "factor unit finished outside the calc state")
  `DNA_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_acc |=> !s_axis_tready,
    "new transaction taken while a hit is in work")
  `DNA_ASSERT_NEVER(a_reject_zero_inc, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tuser[0] && (m_axis_tdata[47:0] != '0),
    "rejected hit carries a dose increment")

endmodule

`default_nettype wire

// File: rtl/dna_factor.sv
// ----------------------------------------------------------------------------
// dna_factor
// Iterative dose increment unit: segment lookup, bit-serial interpolation
// product, restoring division by the segment width, path scaling and a
// shift-add division by ten.
// ----------------------------------------------------------------------------
`default_nettype none

module dna_factor (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dna_pkg::fac_req_t req_i,
  output dna_pkg::fac_rsp_t     rsp_o
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_MUL   = 3'd1;
  localparam logic [2:0] F_DIV   = 3'd2;
  localparam logic [2:0] F_SCALE = 3'd3;
  localparam logic [2:0] F_D10A  = 3'd4;
  localparam logic [2:0] F_D10B  = 3'd5;
  localparam logic [2:0] F_D10C  = 3'd6;
  localparam logic [2:0] F_D10D  = 3'd7;

  localparam int unsigned QF = dna_pkg::CW;   // quotient bits of the factor
  localparam int unsigned DW = dna_pkg::CW + dna_pkg::PW;   // scaled product

  logic [2:0]                state_q, state_d;
  logic [dna_pkg::ItW-1:0]   cnt_q, cnt_d;
  logic [dna_pkg::CW-1:0]    ca_q, ca_d, cb_q, cb_d;
  logic [dna_pkg::EW-1:0]    xa_q, xa_d, xb_q, xb_d, dv_q, dv_d;
  logic [dna_pkg::NW-1:0]    acc_q, acc_d, dsh_q, dsh_d;
  logic [dna_pkg::IW-1:0]    q_q, q_d;
  logic [dna_pkg::PW-1:0]    path_q, path_d;
  logic [DW-1:0]             est_q, est_d;
  logic                      done_q, done_d;

  // Segment lookup on the incoming energy
  logic [dna_pkg::SegW-1:0]  seg, seg_lo;
  logic                      clamp_lo, clamp_hi;
  logic [dna_pkg::NW-1:0]    mul_step;
  logic                      div_ge;
  logic [dna_pkg::CW+dna_pkg::PW-1:0] scale_prod;
  logic [DW-1:0]             n10, d10_a0, d10_a, d10_b0, d10_b, d10_c, r10;
  logic                      ge10, ge20;

  always_comb begin
    seg = dna_pkg::SegW'(dna_pkg::NumPoints - 1);
    for (int i = dna_pkg::NumPoints - 1; i >= 1; i--) begin
      if (req_i.energy <= dna_pkg::E_TAB[i]) begin
        seg = dna_pkg::SegW'(i);
      end
    end
    seg_lo   = seg - 1'b1;
    clamp_lo = req_i.energy <= dna_pkg::E_TAB[0];
    clamp_hi = req_i.energy >= dna_pkg::E_TAB[dna_pkg::NumPoints-1];
  end

  // MSB-first shift-add of both interpolation products
  assign mul_step = {acc_q[dna_pkg::NW-2:0], 1'b0}
                  + (xa_q[dna_pkg::EW-1] ? dna_pkg::NW'(ca_q) : '0)
                  + (xb_q[dna_pkg::EW-1] ? dna_pkg::NW'(cb_q) : '0);

  // Restoring division step
  assign div_ge     = acc_q >= dsh_q;
  assign scale_prod = q_q[dna_pkg::CW-1:0] * path_q;

  // Divide by ten: shift-add estimate of n * 0.8 / 8, which never exceeds
  // the true quotient and trails it by at most two, then a remainder fix-up
  always_comb begin
    n10    = acc_q[DW-1:0];
    d10_a0 = (n10 >> 1) + (n10 >> 2);
    d10_a  = d10_a0 + (d10_a0 >> 4);
    d10_b0 = est_q + (est_q >> 8);
    d10_b  = d10_b0 + (d10_b0 >> 16);
    d10_c  = (est_q + (est_q >> 32)) >> 3;
    r10    = n10 - ((est_q << 3) + (est_q << 1));
    ge10   = r10 >= DW'(dna_pkg::PathDivisor);
    ge20   = r10 >= (DW'(dna_pkg::PathDivisor) << 1);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ca_d    = ca_q;
    cb_d    = cb_q;
    xa_d    = xa_q;
    xb_d    = xb_q;
    dv_d    = dv_q;
    acc_d   = acc_q;
    dsh_d   = dsh_q;
    q_d     = q_q;
    path_d  = path_q;
    est_d   = est_q;
    done_d  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          path_d = req_i.path;
          if (clamp_lo || clamp_hi) begin
            q_d     = dna_pkg::IW'(clamp_lo ? dna_pkg::C_TAB[0]
                                            : dna_pkg::C_TAB[dna_pkg::NumPoints-1]);
            state_d = F_SCALE;
          end else begin
            ca_d    = dna_pkg::C_TAB[seg];
            cb_d    = dna_pkg::C_TAB[seg_lo];
            xa_d    = req_i.energy - dna_pkg::E_TAB[seg_lo];
            xb_d    = dna_pkg::E_TAB[seg] - req_i.energy;
            dv_d    = dna_pkg::E_TAB[seg] - dna_pkg::E_TAB[seg_lo];
            acc_d   = '0;
            cnt_d   = dna_pkg::ItW'(dna_pkg::EW - 1);
            state_d = F_MUL;
          end
        end
      end
      F_MUL: begin
        acc_d = mul_step;
        xa_d  = {xa_q[dna_pkg::EW-2:0], 1'b0};
        xb_d  = {xb_q[dna_pkg::EW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          dsh_d   = dna_pkg::NW'(dv_q) << (QF - 1);
          q_d     = '0;
          cnt_d   = dna_pkg::ItW'(QF - 1);
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        if (div_ge) begin
          acc_d = acc_q - dsh_q;
        end
        q_d   = {q_q[dna_pkg::IW-2:0], div_ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = F_SCALE;
        end
      end
      F_SCALE: begin
        acc_d   = dna_pkg::NW'(scale_prod);
        state_d = F_D10A;
      end
      F_D10A: begin
        est_d   = d10_a;
        state_d = F_D10B;
      end
      F_D10B: begin
        est_d   = d10_b;
        state_d = F_D10C;
      end
      F_D10C: begin
        est_d   = d10_c;
        state_d = F_D10D;
      end
      F_D10D: begin
        q_d     = est_q[dna_pkg::IW-1:0] + dna_pkg::IW'(ge10) + dna_pkg::IW'(ge20);
        done_d  = 1'b1;
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    ca_q   <= ca_d;
    cb_q   <= cb_d;
    xa_q   <= xa_d;
    xb_q   <= xb_d;
    dv_q   <= dv_d;
    acc_q  <= acc_d;
    dsh_q  <= dsh_d;
    q_q    <= q_d;
    path_q <= path_d;
    est_q  <= est_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.inc  = q_q;

endmodule

`default_nettype wire

// File: rtl/dna_sum_mem.sv
// ----------------------------------------------------------------------------
// dna_sum_mem
// Per-volume sum memory: one write port, one read port with registered data,
// per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dna_sum_mem #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           rd_en_i,
  input  wire logic [AW-1:0]  rd_addr_i,
  output dna_pkg::sums_t      rd_data_o,
  input  wire logic           wr_en_i,
  input  wire logic [AW-1:0]  wr_addr_i,
  input  wire dna_pkg::sums_t wr_data_i
);

  dna_pkg::sums_t mem_q [Depth];
  dna_pkg::sums_t rdat_q;
  logic [Depth-1:0] vld_q;
  logic             rvld_q;

  // Storage array and read data register
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdat_q <= mem_q[rd_addr_i];
    end
  end

  // Entry valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdat_q : '0;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for neutron_dose_accumulator_unit. A directed table
// covers rejected volumes, wrong particles, clamped energies, exact break
// points and extreme paths. Random hits follow, checked against an in-bench
// predictor of the interpolation and the per-volume sums. The particle
// register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned   NumVol     = 8;
  localparam int unsigned   NumPts     = 22;
  localparam int unsigned   NumPhases  = 5;
  localparam int unsigned   HitsPerPh  = 250;
  localparam int unsigned   DrainWait  = 140;
  localparam longint        CycleLimit = 1200000;
  localparam logic [23:0]   Neutron    = 24'd2112;

  // Break points (2^-36 MeV) and factors (2^-40)
  localparam logic [44:0] BreakE [NumPts] = '{
    45'd1718, 45'd6872, 45'd68719, 45'd687195, 45'd6871948,
    45'd68719477, 45'd687194767, 45'd6871947674, 45'd34359738368,
    45'd68719476736, 45'd171798691840, 45'd343597383680, 45'd481036337152,
    45'd687194767360, 45'd962072674304, 45'd1374389534720,
    45'd2748779069440, 45'd4123168604160, 45'd6871947673600,
    45'd13743895347200, 45'd20615843020800, 45'd27487790694400
  };
  localparam logic [26:0] Factor [NumPts] = '{
    27'd1122601, 27'd1122601, 27'd1363394, 27'd1363394, 27'd1316115,
    27'd1122601, 27'd1090825, 27'd6639951, 27'd28279439, 27'd40187150,
    27'd38175044, 27'd47718805, 27'd44915050, 27'd44915050, 27'd63628738,
    27'd69412169, 27'd76350087, 27'd69412169, 27'd54535777, 27'd58735911,
    27'd69412169, 27'd76350087
  };

  typedef struct {
    logic        acc;
    logic [47:0] inc;
    logic [63:0] dose;
    logic [31:0] hits;
    logic [63:0] energy;
    logic [63:0] path;
  } tally_t;

  typedef struct {
    logic [3:0]  vol;
    logic [23:0] code;
    logic [44:0] energy;
    logic [23:0] path;
    bit          typed;
    logic        acc;
    logic [47:0] inc;
  } hit_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [271:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [23:0]  cfg_wdata_i = '0;

  // Predictor state
  logic [23:0] particle_sel;
  logic [63:0] dose_acc [NumVol];
  logic [31:0] hit_acc [NumVol];
  logic [63:0] energy_acc [NumVol];
  logic [63:0] path_acc [NumVol];

  tally_t   tally_q [$];
  int       errors = 0;
  int       hits_sent = 0;
  int       hits_taken = 0;
  int       hits_accepted = 0;
  longint   cycles = 0;
  bit       no_gaps = 1'b0;

  neutron_dose_accumulator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, tally_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Interpolated dose factor, clamped at both ends
  function automatic logic [63:0] interp_factor(logic [44:0] e);
    logic [127:0] num;
    if (e <= BreakE[0]) return 64'(Factor[0]);
    if (e >= BreakE[NumPts-1]) return 64'(Factor[NumPts-1]);
    for (int i = 1; i < NumPts; i++) begin
      if (e >= BreakE[i-1] && e <= BreakE[i]) begin
        num = 128'(Factor[i]) * 128'(e - BreakE[i-1])
            + 128'(Factor[i-1]) * 128'(BreakE[i] - e);
        return 64'(num / 128'(BreakE[i] - BreakE[i-1]));
      end
    end
    return 64'(Factor[NumPts-1]);
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Update the per-volume sums and form the expected result
  task automatic tally_hit(input logic [3:0] vol, input logic [23:0] code,
                           input logic [44:0] e, input logic [23:0] p,
                           output tally_t r);
    int k;
    logic [63:0] prod;
    r = '{default: '0};
    if (vol >= 1 && vol <= NumVol) begin
      k = vol - 1;
      if (code == particle_sel) begin
        prod = interp_factor(e) * 64'(p) / 64'd10;
        r.acc = 1'b1;
        r.inc = prod[47:0];
        dose_acc[k]   = sat_sum(dose_acc[k], 64'(r.inc));
        if (hit_acc[k] != '1) hit_acc[k]++;
        energy_acc[k] = sat_sum(energy_acc[k], 64'(e));
        path_acc[k]   = sat_sum(path_acc[k], 64'(p));
      end
      r.dose = dose_acc[k];
      r.hits = hit_acc[k];
      r.energy = energy_acc[k];
      r.path = path_acc[k];
    end
  endtask

  // Send one hit with a random lead-in gap
  task automatic send_hit(input hit_row_t h);
    int gap;
    tally_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {7'b0, h.path, h.energy, h.code, h.vol};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tally_hit(h.vol, h.code, h.energy, h.path, r);
    if (h.typed) begin
      if (r.acc !== h.acc || r.inc !== h.inc)
        $display("%0t: note: table row differs from predictor", $time);
      r.acc = h.acc;
      r.inc = h.inc;
    end
    tally_q.push_back(r);
    hits_sent++;
  endtask

  task automatic write_particle(input logic [23:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    particle_sel = v;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [44:0] pick_energy();
    int k;
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    k = $urandom_range(1, NumPts - 1);
    case ($urandom_range(0, 5))
      0: return r64[44:0];
      1: return BreakE[0] - 45'(r64 % 64'(BreakE[0] + 1));
      2: return BreakE[k] + 45'($urandom_range(0, 2)) - 45'd1;
      3: return BreakE[NumPts-1] + 45'(r64 % 64'(45'h1FFFFFFFFFFF - BreakE[NumPts-1] + 1));
      default: return BreakE[k-1] + 45'(r64 % 64'(BreakE[k] - BreakE[k-1] + 1));
    endcase
  endfunction

  function automatic hit_row_t random_hit();
    hit_row_t h;
    h = '{default: '0};
    h.vol    = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, NumVol))
                                          : 4'($urandom_range(0, 15));
    h.code   = ($urandom_range(0, 9) < 8) ? particle_sel : 24'($urandom);
    h.energy = pick_energy();
    h.path   = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 4096))
                                           : 24'($urandom);
    return h;
  endfunction

  // Result side: random stall before each transaction
  initial begin
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    tally_t x;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      hits_taken++;
      if (tally_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %0h", $time, m_axis_tdata);
      end else begin
        x = tally_q.pop_front();
        if (x.acc) hits_accepted++;
        check_field("accepted", 64'(x.acc), 64'(m_axis_tuser[0]));
        check_field("dose_increment", 64'(x.inc), 64'(m_axis_tdata[47:0]));
        check_field("volume_dose_sum", x.dose, m_axis_tdata[111:48]);
        check_field("volume_hit_count", 64'(x.hits), 64'(m_axis_tdata[143:112]));
        check_field("volume_energy_sum", x.energy, m_axis_tdata[207:144]);
        check_field("volume_path_sum", x.path, m_axis_tdata[271:208]);
      end
    end
  end

  // Directed hits; typed results for rejects, clamps, break points and a zero path
  hit_row_t directed [] = '{
    '{4'd0,  Neutron,   45'd1000,          24'd10,       1, 1'b0, 48'd0},
    '{4'd9,  Neutron,   45'd1000,          24'd10,       1, 1'b0, 48'd0},
    '{4'd15, Neutron,   45'h1FFFFFFFFFFF,  24'hFFFFFF,   1, 1'b0, 48'd0},
    '{4'd3,  24'd2212,  45'd5000,          24'd10,       1, 1'b0, 48'd0},
    '{4'd1,  Neutron,   45'd0,             24'd10,       1, 1'b1, 48'd1122601},
    '{4'd8,  Neutron,   45'h1FFFFFFFFFFF,  24'd10,       1, 1'b1, 48'd76350087},
    '{4'd2,  Neutron,   45'd1718,          24'd10,       1, 1'b1, 48'd1122601},
    '{4'd2,  Neutron,   45'd27487790694400, 24'd10,      1, 1'b1, 48'd76350087},
    '{4'd4,  Neutron,   45'd34359738368,   24'd10,       1, 1'b1, 48'd28279439},
    '{4'd5,  Neutron,   45'd5000000,       24'd0,        1, 1'b1, 48'd0},
    '{4'd6,  Neutron,   45'd1000000000,    24'hFFFFFF,   0, 1'b0, 48'd0},
    '{4'd7,  Neutron,   45'd400000000000,  24'd123456,   0, 1'b0, 48'd0},
    '{4'd7,  Neutron,   45'd50000000000,   24'hFFFFFF,   0, 1'b0, 48'd0},
    '{4'd1,  24'h7FFFFF, 45'd1718,         24'd10,       1, 1'b0, 48'd0},
    '{4'd1,  24'h800000, 45'd1718,         24'd10,       1, 1'b0, 48'd0},
    '{4'd8,  Neutron,   45'd9000000000000, 24'd256,      0, 1'b0, 48'd0}
  };

  // Main sequence
  initial begin
    logic [23:0] phase_code [NumPhases];
    phase_code = '{Neutron, 24'h800000, 24'h7FFFFF, 24'd0, 24'($urandom)};
    particle_sel = Neutron;
    for (int v = 0; v < NumVol; v++) begin
      dose_acc[v] = '0; hit_acc[v] = '0; energy_acc[v] = '0; path_acc[v] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_hit(directed[i]);
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_particle(phase_code[ph]);
      for (int n = 0; n < HitsPerPh; n++) begin
        // stretches without any idling on either side
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_hit(random_hit());
      end
      no_gaps = 1'b0;
      wait_idle();
    end

    $display("Covered %0d hits (%0d accepted, %0d results) over %0d particle settings",
             hits_sent, hits_accepted, hits_taken, NumPhases);
    $display("including rejects, clamped and break-point energies, extreme paths.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
